// ===== rtl/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// swd_pkg: shared types and constants of the duplicate detector
// Field widths, verdict codes and the records passed between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package swd_pkg;

    localparam int SLOT_W      = 4;
    localparam int SEQ_W       = 32;
    localparam int WIDTH_W     = 6;
    localparam int SPAN_W      = 7;
    localparam int SEQ_W_MIN   = 8;
    localparam int SEQ_W_MAX   = 32;
    localparam logic [SEQ_W-1:0] SEQ_ONES = 32'hffff_ffff;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 7'd64;

    typedef enum logic [2:0] {
        V_NEWER   = 3'd0,
        V_OLD_IN  = 3'd1,
        V_RESET   = 3'd2,
        V_WIN_DUP = 3'd3,
        V_REPEAT  = 3'd4,
        V_BAD     = 3'd5
    } t_verdict;

    // classified item, front to back
    typedef struct packed {
        logic               bad;
        logic [SLOT_W-1:0]  slot;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   mask;
        logic [WIDTH_W-1:0] width;
    } t_cmd;

    // result item, back to output queue
    typedef struct packed {
        logic     is_dup;
        t_verdict verdict;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/swd_ram.sv =====
// ----------------------------------------------------------------------------
// swd_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swd_fifo.sv =====
// ----------------------------------------------------------------------------
// swd_fifo: small synchronous queue
// Push/full on the write side, pop/empty on the read side, head shown directly.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // store pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swd_front.sv =====
// ----------------------------------------------------------------------------
// swd_front: input classifier
// Checks slot and width, masks the sequence and queues a command record.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_front
    import swd_pkg::*;
#(
    parameter int NUM_FLOWS = 16
) (
    input  wire logic               i_push,
    input  wire logic [SLOT_W-1:0]  i_flow_slot,
    input  wire logic [SEQ_W-1:0]   i_seq_value,
    input  wire logic [WIDTH_W-1:0] i_seq_width,
    output logic                    o_full,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output t_cmd                    o_cmd
);

    logic             slot_bad;
    logic             width_bad;
    logic [SEQ_W-1:0] mask;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    // classify and mask
    always_comb begin
        slot_bad  = (32'(i_flow_slot) >= NUM_FLOWS);
        width_bad = (i_seq_width < WIDTH_W'(SEQ_W_MIN)) || (i_seq_width > WIDTH_W'(SEQ_W_MAX));
        mask      = SEQ_ONES >> (WIDTH_W'(SEQ_W) - i_seq_width);
        o_cmd.bad   = slot_bad || width_bad;
        o_cmd.slot  = i_flow_slot;
        o_cmd.seq   = i_seq_value & mask;
        o_cmd.mask  = mask;
        o_cmd.width = i_seq_width;
    end

endmodule

`default_nettype wire

// ===== rtl/swd_back.sv =====
// ----------------------------------------------------------------------------
// swd_back: per-flow window update engine
// Reads flow state, decides the verdict, writes back the new window state.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_back
    import swd_pkg::*;
#(
    parameter int NUM_FLOWS  = 16,
    parameter int WINDOW_MAX = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [SPAN_W-1:0] i_span,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_cmd_empty,
    output logic                   o_cmd_pop,
    output t_result                o_res,
    output logic                   o_res_push,
    input  wire logic              i_res_full
);

    localparam int SLOTS = (NUM_FLOWS < (2 ** SLOT_W)) ? NUM_FLOWS : (2 ** SLOT_W);
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WB    = $clog2(WINDOW_MAX);
    localparam int EW    = WIDTH_W + SEQ_W + WINDOW_MAX;

    typedef enum logic {
        S_FETCH,
        S_EXEC
    } t_state;

    t_state             r_state, n_state;
    logic [SLOTS-1:0]   r_valid, n_valid;
    t_cmd               r_cmd;

    logic               ram_we;
    logic [EW-1:0]      ram_wdata;
    logic [EW-1:0]      ram_rdata;
    logic [AW-1:0]      slot_idx;

    logic [SPAN_W-1:0]     span;
    logic [WINDOW_MAX-1:0] smask;
    logic [WIDTH_W-1:0]    st_width;
    logic [SEQ_W-1:0]      st_newest;
    logic [WINDOW_MAX-1:0] st_bits;
    logic                  cur_valid;
    logic [SEQ_W-1:0]      sign;
    logic [SEQ_W-1:0]      d;
    logic [SEQ_W-1:0]      ndist;
    logic                  newer;
    logic [WINDOW_MAX-1:0] old_bit;
    logic [SEQ_W-1:0]      w_newest;
    logic [WINDOW_MAX-1:0] w_bits;
    logic                  upd;
    t_verdict              verdict;

    assign slot_idx  = r_cmd.slot[AW-1:0];
    assign st_width  = ram_rdata[EW-1 -: WIDTH_W];
    assign st_newest = ram_rdata[WINDOW_MAX +: SEQ_W];
    assign st_bits   = ram_rdata[WINDOW_MAX-1:0];
    assign cur_valid = r_valid[slot_idx];

    swd_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_idx),
        .i_wdata (ram_wdata),
        .i_re    (o_cmd_pop),
        .i_raddr (i_cmd.slot[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // clamp span and build its bit mask
    always_comb begin
        if (i_span == '0) begin
            span = SPAN_W'(1);
        end else if (i_span > SPAN_W'(WINDOW_MAX)) begin
            span = SPAN_W'(WINDOW_MAX);
        end else begin
            span = i_span;
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            smask[i] = (SPAN_W'(i) < span);
        end
    end

    // distances and direction
    always_comb begin
        sign    = r_cmd.mask ^ (r_cmd.mask >> 1);
        d       = (r_cmd.seq - st_newest) & r_cmd.mask;
        ndist   = (st_newest - r_cmd.seq) & r_cmd.mask;
        newer   = (d < sign) || ((d == sign) && (r_cmd.seq > st_newest));
        old_bit = WINDOW_MAX'(1) << ndist[WB-1:0];
    end

    // decide verdict and new flow state
    always_comb begin
        verdict  = V_BAD;
        upd      = 1'b0;
        w_newest = r_cmd.seq;
        w_bits   = WINDOW_MAX'(1);
        if (r_cmd.bad) begin
            verdict = V_BAD;
        end else if (!cur_valid) begin
            verdict = V_NEWER;
            upd     = 1'b1;
        end else if (st_width != r_cmd.width) begin
            verdict = V_BAD;
        end else if (d == '0) begin
            verdict = V_REPEAT;
        end else if (newer) begin
            verdict = V_NEWER;
            upd     = 1'b1;
            if (d < SEQ_W'(span)) begin
                w_bits = ((st_bits << d[WB-1:0]) | WINDOW_MAX'(1)) & smask;
            end
        end else if (ndist < SEQ_W'(span)) begin
            w_newest = st_newest;
            if ((st_bits & old_bit) != '0) begin
                verdict = V_WIN_DUP;
            end else begin
                verdict = V_OLD_IN;
                upd     = 1'b1;
                w_bits  = (st_bits | old_bit) & smask;
            end
        end else begin
            verdict = V_RESET;
            upd     = 1'b1;
        end
    end

    // sequence fetch and execute
    always_comb begin
        n_state        = r_state;
        n_valid        = r_valid;
        o_cmd_pop      = 1'b0;
        o_res_push     = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = {r_cmd.width, w_newest, w_bits};
        o_res.verdict  = verdict;
        o_res.is_dup   = (verdict >= V_WIN_DUP);
        unique case (r_state)
            S_FETCH: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    ram_we     = upd;
                    if (upd) begin
                        n_valid[slot_idx] = 1'b1;
                    end
                    n_state = S_FETCH;
                end
            end
            default: n_state = S_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FETCH;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (o_cmd_pop) begin
                r_cmd <= i_cmd;
            end
        end
    end

    // a fetched command is always executed next
    a_pop_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == S_EXEC))
        else $error("command fetch not followed by execute");

    // state is written only while a result is delivered
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (o_res_push && (r_state == S_EXEC)))
        else $error("flow state written without result");

    // rejected commands never touch flow state
    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we || (n_valid != r_valid)) |-> !r_cmd.bad)
        else $error("rejected command changed flow state");

    // duplicates leave flow state alone
    a_dup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.is_dup) |-> !ram_we)
        else $error("duplicate changed flow state");

endmodule

`default_nettype wire

// ===== rtl/sliding_window_dup_detector.sv =====
// ----------------------------------------------------------------------------
// sliding_window_dup_detector: per-flow anti-replay window
// Flags repeated or stale sequence numbers per flow with a sliding bitmap.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Payload
//   --------  ---------  ---------------  ---------------------------------------
//   items     in         push / full      i_flow_slot, i_seq_value, i_seq_width
//   results   out        empty / pop      o_is_dup, o_verdict
//   config    in         i_cfg_we         i_cfg_wdata (window span)
//
// Each item passes the back end in a fetch state, which reads the flow state RAM,
// then an execute state, which decides and writes the state back; no new item is
// fetched until this read-modify-write is done, and this sets the rate.
// Reset is synchronous; it clears flow valid bits and restores the span to 64.
// A two-entry command queue and a two-entry result queue let input and output
// stall independently; a full result queue holds the back end in execute.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_dup_detector
    import swd_pkg::*;
#(
    parameter int NUM_FLOWS  = 16,
    parameter int WINDOW_MAX = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [SLOT_W-1:0]  i_flow_slot,
    input  wire logic [SEQ_W-1:0]   i_seq_value,
    input  wire logic [WIDTH_W-1:0] i_seq_width,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_is_dup,
    output logic [2:0]              o_verdict,
    input  wire logic               i_cfg_we,
    input  wire logic [SPAN_W-1:0]  i_cfg_wdata
);

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    logic [SPAN_W-1:0]        r_window_span;
    t_cmd                     front_cmd;
    logic                     front_push;
    logic                     cmd_full;
    logic [$bits(t_cmd)-1:0]  cmd_q_data;
    t_cmd                     cmd_head;
    logic                     cmd_empty;
    logic                     cmd_pop;
    t_result                  back_res;
    logic                     res_push;
    logic                     res_full;
    logic [$bits(t_result)-1:0] res_q_data;
    t_result                  res_head;

    // hold window span register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_span <= SPAN_RESET;
        end else if (i_cfg_we) begin
            r_window_span <= i_cfg_wdata;
        end
    end

    swd_front #(
        .NUM_FLOWS (NUM_FLOWS)
    ) u_front (
        .i_push      (push),
        .i_flow_slot (i_flow_slot),
        .i_seq_value (i_seq_value),
        .i_seq_width (i_seq_width),
        .o_full      (full),
        .i_q_full    (cmd_full),
        .o_q_push    (front_push),
        .o_cmd       (front_cmd)
    );

    swd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q_data),
        .o_empty (cmd_empty)
    );

    assign cmd_head = t_cmd'(cmd_q_data);

    swd_back #(
        .NUM_FLOWS  (NUM_FLOWS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_span      (r_window_span),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    swd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q_data),
        .o_empty (empty)
    );

    // drive result ports from queue head
    assign res_head  = t_result'(res_q_data);
    assign o_is_dup  = res_head.is_dup;
    assign o_verdict = res_head.verdict;

endmodule

`default_nettype wire

// ===== tb/swd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_checker: result predictor and scoreboard for the duplicate detector
// Watches the item, result and span channels. On each accepted item it
// updates its own per-flow window state and queues the expected verdict.
// Each result transfer is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------

module swd_checker
    import swd_pkg::*;
#(
    parameter int NUM_FLOWS  = 16,
    parameter int WINDOW_MAX = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic [SLOT_W-1:0]  i_flow_slot,
    input  wire logic [SEQ_W-1:0]   i_seq_value,
    input  wire logic [WIDTH_W-1:0] i_seq_width,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic               i_is_dup,
    input  wire logic [2:0]         i_verdict,
    input  wire logic               i_cfg_we,
    input  wire logic [SPAN_W-1:0]  i_cfg_wdata,
    output int                      o_pending,
    output int                      o_errors
);

    // per-flow window state and the span register, as the block should hold them
    logic               flow_live [NUM_FLOWS];
    logic [WIDTH_W-1:0] flow_bits [NUM_FLOWS];
    logic [SEQ_W-1:0]   flow_head [NUM_FLOWS];
    logic [63:0]        flow_seen [NUM_FLOWS];
    logic [SPAN_W-1:0]  span_reg;

    t_result verdict_q [$];
    int      errors = 0;

    assign o_errors = errors;

    // classify one packet against its flow window and update the window
    function automatic t_verdict judge_packet(input logic [SLOT_W-1:0] slot,
                                              input logic [SEQ_W-1:0] raw,
                                              input logic [WIDTH_W-1:0] w);
        logic [SEQ_W-1:0] mask;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] half;
        logic [SEQ_W-1:0] fwd;
        logic [SEQ_W-1:0] back;
        logic [63:0]      keep;
        int               span;
        if (int'(slot) >= NUM_FLOWS) return V_BAD;
        if (w < SEQ_W_MIN || w > SEQ_W_MAX) return V_BAD;
        mask = SEQ_ONES >> (SEQ_W_MAX - int'(w));
        seq  = raw & mask;

        // first good packet opens the flow
        if (!flow_live[slot]) begin
            flow_live[slot] = 1'b1;
            flow_bits[slot] = w;
            flow_head[slot] = seq;
            flow_seen[slot] = 64'd1;
            return V_NEWER;
        end
        if (flow_bits[slot] != w) return V_BAD;

        // clamp the span register into 1..WINDOW_MAX
        span = int'(span_reg);
        if (span == 0) span = 1;
        if (span > WINDOW_MAX) span = WINDOW_MAX;
        keep = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
        half = 32'd1 << (int'(w) - 1);
        fwd  = (seq - flow_head[slot]) & mask;

        if (fwd == 0) return V_REPEAT;

        // ahead of the newest: slide the bitmap, or clear it on a long jump
        if (fwd < half || (fwd == half && seq > flow_head[slot])) begin
            if (fwd < span)
                flow_seen[slot] = ((flow_seen[slot] << fwd) | 64'd1) & keep;
            else
                flow_seen[slot] = 64'd1;
            flow_head[slot] = seq;
            return V_NEWER;
        end

        // behind the newest: test and mark inside the window
        back = (flow_head[slot] - seq) & mask;
        if (back < span) begin
            if (flow_seen[slot][back]) return V_WIN_DUP;
            flow_seen[slot] = (flow_seen[slot] | (64'd1 << back)) & keep;
            return V_OLD_IN;
        end

        // too far behind: restart the window at this packet
        flow_seen[slot] = 64'd1;
        flow_head[slot] = seq;
        return V_RESET;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FLOWS; k++) flow_live[k] = 1'b0;
            span_reg = SPAN_RESET;
            verdict_q.delete();
        end else begin
            // compare a result transfer with the oldest expectation
            if (i_pop && !i_empty) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got verdict %0d is_dup %0b",
                             $time, i_verdict, i_is_dup);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_is_dup !== want.is_dup) begin
                        errors++;
                        $display("%0t: is_dup mismatch: expected %0b, got %0b",
                                 $time, want.is_dup, i_is_dup);
                    end
                    if (i_verdict !== want.verdict) begin
                        errors++;
                        $display("%0t: verdict mismatch: expected %0d, got %0d",
                                 $time, want.verdict, i_verdict);
                    end
                end
            end

            // span write
            if (i_cfg_we) span_reg = i_cfg_wdata;

            // predict an item transfer
            if (i_push && !i_full) begin
                want.verdict = judge_packet(i_flow_slot, i_seq_value, i_seq_width);
                want.is_dup  = (want.verdict >= V_WIN_DUP);
                verdict_q.push_back(want);
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the sliding window duplicate detector
// Drives directed corner packets, then phases of random flow traffic at
// several window spans, with random stalls on both channels. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_top
    import swd_pkg::*;
();

    localparam int PHASE_ITEMS = 147;
    localparam int PHASES      = 7;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               pop         = 1'b0;
    logic [SLOT_W-1:0]  flow_slot   = '0;
    logic [SEQ_W-1:0]   seq_value   = '0;
    logic [WIDTH_W-1:0] seq_width   = '0;
    logic               cfg_we      = 1'b0;
    logic [SPAN_W-1:0]  cfg_wdata   = '0;
    wire                full;
    wire                empty;
    wire                is_dup;
    wire  [2:0]         verdict;
    int                 pending;
    int                 errors;

    bit                 calm       = 1'b0;
    int                 stall_left = 0;
    int                 span_now   = 64;

    // stimulus-side view of each flow: width, rough newest and whether opened
    logic [WIDTH_W-1:0] lane_width [16];
    logic [SEQ_W-1:0]   lane_head  [16];
    bit                 lane_live  [16];

    logic [SPAN_W-1:0]  span_plan [PHASES];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    sliding_window_dup_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_flow_slot (flow_slot),
        .i_seq_value (seq_value),
        .i_seq_width (seq_width),
        .empty       (empty),
        .pop         (pop),
        .o_is_dup    (is_dup),
        .o_verdict   (verdict),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    swd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_flow_slot (flow_slot),
        .i_seq_value (seq_value),
        .i_seq_width (seq_width),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_is_dup    (is_dup),
        .i_verdict   (verdict),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // result side: pop with random stall bursts, none once calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 13);
            pop        <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // offer one packet and hold it until the transfer, then maybe idle
    task automatic offer_packet(input logic [SLOT_W-1:0] s, input logic [SEQ_W-1:0] q,
                                input logic [WIDTH_W-1:0] w);
        flow_slot <= s;
        seq_value <= q;
        seq_width <= w;
        push      <= 1'b1;
        do @(posedge i_clk); while (full);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // drop push and wait until every expected result has been popped
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // write the span register while the block is idle
    task automatic write_span(input logic [SPAN_W-1:0] v);
        settle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        span_now = (v == 0) ? 1 : ((v > 64) ? 64 : int'(v));
    endtask

    // mostly well-formed flow traffic with some broken and noise packets
    task automatic random_packet();
        int               slot_i;
        int               w;
        int               kind;
        logic [SEQ_W-1:0] mask;
        logic [SEQ_W-1:0] q;
        slot_i = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        w      = lane_width[slot_i];
        mask   = SEQ_ONES >> (32 - w);
        q      = lane_head[slot_i];
        kind   = $urandom_range(0, 99);
        if (kind < 45) begin
            // advance, mostly inside the window
            q = q + $urandom_range(1, (kind < 38) ? span_now + 4 : 300);
            lane_head[slot_i] = q & mask;
        end else if (kind < 75) begin
            // step back, around the window edge
            q = q - $urandom_range(0, span_now + 4);
        end else if (kind < 83) begin
            // arbitrary jump
            q = $urandom();
            lane_head[slot_i] = q & mask;
        end else if (kind < 88) begin
            // exactly half the sequence range away
            q = q ^ (32'd1 << (w - 1));
            lane_head[slot_i] = q & mask;
        end else if (kind < 94) begin
            // wrong width; keep it out of range while the flow is unopened
            q = $urandom();
            if (lane_live[slot_i]) begin
                do w = $urandom_range(0, 63); while (w == lane_width[slot_i]);
            end else begin
                w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom_range(33, 63);
            end
        end else begin
            // noise on a good width
            q = $urandom();
        end
        if (w == lane_width[slot_i]) lane_live[slot_i] = 1'b1;
        // junk above the width is ignored by the block
        if ($urandom_range(0, 3) == 0) q = q | ($urandom() & ~mask);
        else if (w == lane_width[slot_i]) q = q & mask;
        offer_packet(slot_i[SLOT_W-1:0], q, w[WIDTH_W-1:0]);
    endtask

    initial begin
        for (int k = 0; k < 16; k++) begin
            lane_width[k] = WIDTH_W'($urandom_range(SEQ_W_MIN, SEQ_W_MAX));
            lane_head[k]  = $urandom() & (SEQ_ONES >> (32 - int'(lane_width[k])));
            lane_live[k]  = 1'b0;
        end
        lane_width[0]  = 6'd8;
        lane_width[1]  = 6'd32;
        lane_width[2]  = 6'd8;
        lane_width[15] = 6'd32;
        span_plan = '{7'd127, 7'd0, 7'd1, 7'd8, 7'd33, 7'd64, 7'd0};
        span_plan[PHASES-1] = SPAN_W'($urandom_range(2, 126));

        // hold reset, then release
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bad widths never open a flow
        offer_packet(4'd0, 32'd0, 6'd0);
        offer_packet(4'd1, 32'h0000_1234, 6'd63);
        offer_packet(4'd1, 32'd0, 6'd7);
        offer_packet(4'd1, 32'd0, 6'd33);
        // 8-bit flow: junk high bits, repeat, width change, in-window dup
        offer_packet(4'd0, 32'hffff_ff05, 6'd8);
        offer_packet(4'd0, 32'd5, 6'd8);
        offer_packet(4'd0, 32'd6, 6'd16);
        offer_packet(4'd0, 32'd6, 6'd8);
        offer_packet(4'd0, 32'd4, 6'd8);
        offer_packet(4'd0, 32'd4, 6'd8);
        // half range ahead, then half range behind
        offer_packet(4'd0, 32'h86, 6'd8);
        offer_packet(4'd0, 32'd6, 6'd8);
        // 32-bit flow: wrap through zero and the half range both ways
        offer_packet(4'd15, 32'hffff_ffff, 6'd32);
        offer_packet(4'd15, 32'd0, 6'd32);
        offer_packet(4'd15, 32'h7fff_ffff, 6'd32);
        offer_packet(4'd15, 32'hffff_ffff, 6'd32);
        offer_packet(4'd15, 32'h7fff_ffff, 6'd32);
        // window edge: slide to the last bit, hit it, slide past, clear
        offer_packet(4'd2, 32'd10, 6'd8);
        offer_packet(4'd2, 32'd73, 6'd8);
        offer_packet(4'd2, 32'd10, 6'd8);
        offer_packet(4'd2, 32'd74, 6'd8);
        offer_packet(4'd2, 32'd138, 6'd8);
        offer_packet(4'd2, 32'd74, 6'd8);
        lane_head[0]  = 32'd6;
        lane_head[2]  = 32'd74;
        lane_head[15] = 32'h7fff_ffff;
        lane_live[0]  = 1'b1;
        lane_live[2]  = 1'b1;
        lane_live[15] = 1'b1;

        // random phases, one span setting each; the last one runs without idling
        for (int p = 0; p < PHASES; p++) begin
            write_span(span_plan[p]);
            if (p == PHASES - 1) calm = 1'b1;
            repeat (PHASE_ITEMS) random_packet();
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("** sliding_window_dup_detector: PASSED **");
        end else begin
            $display("** sliding_window_dup_detector: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("** sliding_window_dup_detector: FAILED **");
        $finish;
    end

endmodule
